[rtl/core/fki_pkg.sv]
// Shared types, constants and arithmetic helpers of the flight kinematics integrator.
package fki_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic signed [17:0] ANG_PI       = 18'sd25736;
  localparam logic signed [17:0] ANG_2PI      = 18'sd51472;
  localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
  localparam logic [12:0]        FULL_THR     = 13'd4096;
  localparam logic [32:0]        RECIP9       = 33'd477218589;
  localparam logic [32:0]        RECIP5       = 33'd858993460;
  localparam logic [32:0]        DAMP_MUL     = 33'd36864;
  localparam logic [32:0]        HEADING_MUL  = 33'd58671;
  localparam logic [15:0]        FULL_CIRCLE  = 16'd46080;
  localparam logic [15:0]        DAMP_LIMIT   = 16'd819;

  localparam int IN_W  = 80;
  localparam int OUT_W = 160;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MIN_ALT  = 3'd0;
  localparam logic [2:0] REG_BASE_SPD = 3'd1;
  localparam logic [2:0] REG_SPAN_SPD = 3'd2;
  localparam logic [2:0] REG_P_GAIN   = 3'd3;
  localparam logic [2:0] REG_R_GAIN   = 3'd4;
  localparam logic [2:0] REG_Y_GAIN   = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE, S_PG, S_PDT, S_PUPD, S_RG, S_RDT, S_RUPD, S_YG, S_YDT, S_YUPD,
    S_KMH, S_SPD, S_SPDW,
    S_CINIT_P, S_CITER_P, S_CEND_P, S_CINIT_Y, S_CITER_Y, S_CEND_Y,
    S_FX, S_FXW, S_FZ, S_FZW, S_VX, S_VXW, S_VZ, S_VZW, S_VY, S_VYW,
    S_PX, S_PXW, S_PZ, S_PZW, S_PY, S_PYW,
    S_FLOOR, S_DAMPQ, S_DAMPW, S_HDG, S_HDGW
  } st_t;

  typedef struct packed {
    logic [15:0] min_alt;
    logic [9:0]  base_spd;
    logic [9:0]  span_spd;
    logic [15:0] pitch_gain;
    logic [15:0] roll_gain;
    logic [15:0] yaw_gain;
  } cfg_t;

  typedef struct packed {
    st_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v,
                                               input logic [4:0] s);
    logic signed [65:0] mag;
    logic signed [65:0] half;
    logic signed [65:0] r;
    mag  = (v < 0) ? -v : v;
    half = 66'sd1 <<< (s - 5'd1);
    r    = (mag + half) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  // One wrap by a full turn, then a clamp to the half-turn limits.
  function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] w;
    w = a;
    if (w > ANG_PI) w = w - ANG_2PI;
    if (w < -ANG_PI) w = w + ANG_2PI;
    if (w > ANG_PI) w = ANG_PI;
    if (w < -ANG_PI) w = -ANG_PI;
    return w[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/flight_kinematics_integrator.sv]
// An accepted tick is stepped through the sequencer's states and its result goes to the output
// register. A new tick is taken only once the last is through, as the one shared multiplier
// and the CORDIC rotator, which runs once for pitch and once for yaw, serve all of its steps.
// A finished result waits in the output register while the next tick is taken.
// Reset (synchronous, active low) clears angles and east/north, sets altitude to 1000 m
// and loads the register defaults.
module flight_kinematics_integrator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pitch_cmd[15:0], roll_cmd[31:16], yaw_cmd[47:32], throttle_level[60:48],
  // time_step[76:61], zero fill to 79
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // east_pos[31:0], up_pos[63:32], north_pos[95:64], pitch_out[111:96],
  // roll_out[127:112], yaw_out[143:128], heading_deg[159:144]
  output logic [159:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fki_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  fki_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  fki_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd
  );

  fki_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg,
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

[rtl/core/fki_regs.sv]
// Configuration register file behind the APB-style port.
module fki_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output fki_pkg::cfg_t     cfg
);
  import fki_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_alt    <= 16'd100;
      cfg_r.base_spd   <= 10'd100;
      cfg_r.span_spd   <= 10'd200;
      cfg_r.pitch_gain <= 16'd8192;
      cfg_r.roll_gain  <= 16'd13107;
      cfg_r.yaw_gain   <= 16'd4915;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_ALT:  cfg_r.min_alt    <= cfg_pwdata[15:0];
        REG_BASE_SPD: cfg_r.base_spd   <= cfg_pwdata[9:0];
        REG_SPAN_SPD: cfg_r.span_spd   <= cfg_pwdata[9:0];
        REG_P_GAIN:   cfg_r.pitch_gain <= cfg_pwdata[15:0];
        REG_R_GAIN:   cfg_r.roll_gain  <= cfg_pwdata[15:0];
        REG_Y_GAIN:   cfg_r.yaw_gain   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_ALT:  cfg_prdata = 32'(cfg_r.min_alt);
      REG_BASE_SPD: cfg_prdata = 32'(cfg_r.base_spd);
      REG_SPAN_SPD: cfg_prdata = 32'(cfg_r.span_spd);
      REG_P_GAIN:   cfg_prdata = 32'(cfg_r.pitch_gain);
      REG_R_GAIN:   cfg_prdata = 32'(cfg_r.roll_gain);
      REG_Y_GAIN:   cfg_prdata = 32'(cfg_r.yaw_gain);
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/fki_ctrl.sv]
// Sequencer that steps the datapath through one tick of the integration.
module fki_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fki_pkg::sts_t sts,
  output fki_pkg::cmd_t cmd
);
  import fki_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    cmd.op    = state_r;
    cmd.load  = in_tready & in_tvalid;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_PG;
      S_PG:      state_nxt = S_PDT;
      S_PDT:     state_nxt = S_PUPD;
      S_PUPD:    state_nxt = S_RG;
      S_RG:      state_nxt = S_RDT;
      S_RDT:     state_nxt = S_RUPD;
      S_RUPD:    state_nxt = S_YG;
      S_YG:      state_nxt = S_YDT;
      S_YDT:     state_nxt = S_YUPD;
      S_YUPD:    state_nxt = S_KMH;
      S_KMH:     state_nxt = S_SPD;
      S_SPD:     state_nxt = S_SPDW;
      S_SPDW:    state_nxt = S_CINIT_P;
      S_CINIT_P: state_nxt = S_CITER_P;
      S_CITER_P: if (sts.cordic_last) state_nxt = S_CEND_P;
      S_CEND_P:  state_nxt = S_CINIT_Y;
      S_CINIT_Y: state_nxt = S_CITER_Y;
      S_CITER_Y: if (sts.cordic_last) state_nxt = S_CEND_Y;
      S_CEND_Y:  state_nxt = S_FX;
      S_FX:      state_nxt = S_FXW;
      S_FXW:     state_nxt = S_FZ;
      S_FZ:      state_nxt = S_FZW;
      S_FZW:     state_nxt = S_VX;
      S_VX:      state_nxt = S_VXW;
      S_VXW:     state_nxt = S_VZ;
      S_VZ:      state_nxt = S_VZW;
      S_VZW:     state_nxt = S_VY;
      S_VY:      state_nxt = S_VYW;
      S_VYW:     state_nxt = S_PX;
      S_PX:      state_nxt = S_PXW;
      S_PXW:     state_nxt = S_PZ;
      S_PZ:      state_nxt = S_PZW;
      S_PZW:     state_nxt = S_PY;
      S_PY:      state_nxt = S_PYW;
      S_PYW:     state_nxt = S_FLOOR;
      S_FLOOR:   state_nxt = S_DAMPQ;
      S_DAMPQ:   state_nxt = S_DAMPW;
      S_DAMPW:   state_nxt = S_HDG;
      S_HDG:     state_nxt = S_HDGW;
      S_HDGW:    if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/fki_dp.sv]
// Datapath: shared multiplier, CORDIC rotator, state accumulators and result register.
module fki_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fki_pkg::cmd_t                cmd,
  output fki_pkg::sts_t                sts,
  input  fki_pkg::cfg_t                cfg,
  input  logic [fki_pkg::IN_W-1:0]     in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fki_pkg::OUT_W-1:0]    out_data
);
  import fki_pkg::*;

  // Latched input beat
  logic signed [15:0] pcmd_r, rcmd_r, ycmd_r;
  logic [12:0]        thr_r;
  logic [15:0]        dt_r;

  // Kinematic state
  logic signed [15:0] pitch_r, roll_r, yaw_r;
  logic signed [31:0] east_r, up_r, north_r;

  // Working registers
  logic signed [65:0] mul_r;
  logic [25:0]        speed_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               cneg_r;
  logic [ITER_W-1:0]  iter_r;
  logic signed [33:0] sp_r, cp_r, sy_r, cyw_r;
  logic signed [32:0] fx_r, fz_r, vx_r, vy_r, vz_r;
  logic               below_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] r31, r30, r24, r16;
  logic [22:0]        kmh;
  logic [28:0]        num;
  logic signed [33:0] z_init, z_fold;
  logic               z_neg;
  logic signed [33:0] x_sh, y_sh, atan_v;
  logic [15:0]        p_abs;
  logic [29:0]        dq;
  logic [16:0]        dmag;
  logic signed [17:0] hd_s;
  logic [15:0]        hd;
  logic [12:0]        thr_c;
  logic               out_free;

  assign out_free        = !out_valid_r || out_ready;
  assign sts.out_free    = out_free;
  assign sts.cordic_last = (iter_r == ITER_W'(CORDIC_STEPS - 1));
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  assign r31 = rnd_sh(mul_r, 5'd31);
  assign r30 = rnd_sh(mul_r, 5'd30);
  assign r24 = rnd_sh(mul_r, 5'd24);
  assign r16 = rnd_sh(mul_r, 5'd16);

  assign thr_c = (thr_r > FULL_THR) ? FULL_THR : thr_r;
  assign kmh   = 23'({cfg.base_spd, 12'd0}) + mul_r[22:0];
  // kmh * 40 + 4 as a sum of shifted copies
  assign num   = 29'({kmh, 5'd0}) + 29'({kmh, 3'd0}) + 29'd4;

  assign p_abs = (pitch_r < 0) ? 16'(-pitch_r) : 16'(pitch_r);
  assign dq    = mul_r[61:32];
  assign dmag  = 17'((31'(dq) + 31'd4096) >> 13);
  assign hd_s  = r16[17:0];
  assign hd    = (hd_s < 0) ? 16'(hd_s + 18'sd46080) : hd_s[15:0];

  // CORDIC: the angle is folded by a half turn when it lies beyond a quarter turn.
  always_comb begin
    z_init = 34'(yaw_r) <<< 17;
    if (cmd.op == S_CINIT_P) z_init = 34'(pitch_r) <<< 17;
    z_neg  = 1'b0;
    z_fold = z_init;
    if (z_init > HALF_PI_Q30) begin
      z_fold = z_init - PI_Q30;
      z_neg  = 1'b1;
    end else if (z_init < -HALF_PI_Q30) begin
      z_fold = z_init + PI_Q30;
      z_neg  = 1'b1;
    end
  end

  assign x_sh   = cx_r >>> iter_r;
  assign y_sh   = cy_r >>> iter_r;
  assign atan_v = atan_q30(5'(iter_r));

  // Multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op) inside
      S_PG:    begin ma = 33'(pcmd_r); mb = 33'(cfg.pitch_gain); end
      S_RG:    begin ma = 33'(rcmd_r); mb = 33'(cfg.roll_gain); end
      S_YG:    begin ma = 33'(ycmd_r); mb = 33'(cfg.yaw_gain); end
      S_PDT, S_RDT, S_YDT: begin ma = mul_r[32:0]; mb = 33'(dt_r); end
      S_KMH:   begin ma = 33'(thr_c); mb = 33'(cfg.span_spd); end
      S_SPD:   begin ma = 33'(num); mb = RECIP9; end
      S_FX:    begin ma = cp_r[32:0]; mb = sy_r[32:0]; end
      S_FZ:    begin ma = cp_r[32:0]; mb = cyw_r[32:0]; end
      S_VX:    begin ma = 33'(speed_r); mb = fx_r; end
      S_VZ:    begin ma = 33'(speed_r); mb = fz_r; end
      S_VY:    begin ma = 33'(speed_r); mb = sp_r[32:0]; end
      S_PX:    begin ma = vx_r; mb = 33'(dt_r); end
      S_PZ:    begin ma = vz_r; mb = 33'(dt_r); end
      S_PY:    begin ma = vy_r; mb = 33'(dt_r); end
      S_FLOOR: begin ma = 33'(p_abs); mb = DAMP_MUL; end
      S_DAMPQ: begin ma = mul_r[32:0]; mb = RECIP5; end
      // The heading product is held while a finished result waits.
      S_HDG, S_HDGW: begin ma = 33'(yaw_r); mb = HEADING_MUL; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= ma * mb;
    if (cmd.load) begin
      pcmd_r <= in_data[15:0];
      rcmd_r <= in_data[31:16];
      ycmd_r <= in_data[47:32];
      thr_r  <= in_data[60:48];
      dt_r   <= in_data[76:61];
    end
    case (cmd.op) inside
      S_SPDW: speed_r <= mul_r[57:32];
      S_CINIT_P, S_CINIT_Y: begin
        cx_r   <= CORDIC_K;
        cy_r   <= '0;
        cz_r   <= z_fold;
        cneg_r <= z_neg;
        iter_r <= '0;
      end
      S_CITER_P, S_CITER_Y: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - y_sh;
          cy_r <= cy_r + x_sh;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + y_sh;
          cy_r <= cy_r - x_sh;
          cz_r <= cz_r + atan_v;
        end
        iter_r <= iter_r + 1'b1;
      end
      S_CEND_P: begin
        sp_r <= cneg_r ? -cy_r : cy_r;
        cp_r <= cneg_r ? -cx_r : cx_r;
      end
      S_CEND_Y: begin
        sy_r  <= cneg_r ? -cy_r : cy_r;
        cyw_r <= cneg_r ? -cx_r : cx_r;
      end
      S_FXW: fx_r <= r30[32:0];
      S_FZW: fz_r <= r30[32:0];
      S_VXW: vx_r <= r30[32:0];
      S_VZW: vz_r <= r30[32:0];
      S_VYW: vy_r <= r30[32:0];
      default: ;
    endcase
    if (cmd.op == S_HDGW && out_free) begin
      out_data_r <= {hd, yaw_r, roll_r, pitch_r, north_r, up_r, east_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r     <= '0;
      roll_r      <= '0;
      yaw_r       <= '0;
      east_r      <= '0;
      up_r        <= 32'sd256000;
      north_r     <= '0;
      below_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == S_HDGW && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op) inside
        S_PUPD: pitch_r <= wrap_ang(18'(pitch_r) + r31[17:0]);
        S_RUPD: roll_r  <= wrap_ang(18'(roll_r) + r31[17:0]);
        S_YUPD: yaw_r   <= wrap_ang(18'(yaw_r) + r31[17:0]);
        S_PXW:  east_r  <= sat32(34'(east_r) + r24[33:0]);
        S_PZW:  north_r <= sat32(34'(north_r) + r24[33:0]);
        S_PYW:  up_r    <= sat32(34'(up_r) + r24[33:0]);
        S_FLOOR: begin
          below_r <= (up_r < $signed({8'd0, cfg.min_alt, 8'd0}));
          if (up_r < $signed({8'd0, cfg.min_alt, 8'd0})) begin
            up_r <= {8'd0, cfg.min_alt, 8'd0};
          end
        end
        S_DAMPW: begin
          // Below the floor pitch is damped by nine tenths, or zeroed when small.
          if (below_r) begin
            if (p_abs > DAMP_LIMIT) begin
              pitch_r <= (pitch_r < 0) ? -16'(dmag) : 16'(dmag);
            end else begin
              pitch_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/fki_checker.sv]
// Port-level checks on the flight kinematics integrator, bound to the top level.
module fki_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // One tick is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a tick is in progress");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[111:96]) <= 16'sd25736) &&
                   ($signed(out_tdata[111:96]) >= -16'sd25736))
    else $error("pitch beyond half a turn");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[159:144] <= 16'd46080)
    else $error("heading beyond a full circle");

endmodule

bind flight_kinematics_integrator fki_checker u_fki_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

[tb/tb_flight_kinematics_integrator.sv]
// Self-checking testbench of the flight kinematics integrator: directed table, then random ticks.
module tb_flight_kinematics_integrator;
  timeunit 1ns;
  timeprecision 1ps;
  import fki_pkg::*;

  localparam int STEPS = CORDIC_STEPS;
  localparam int LIMIT = 3000000;
  localparam int N_RANDOM = 1030;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  flight_kinematics_integrator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0] hdg;
    logic signed [15:0] yaw, roll, pitch;
    logic signed [31:0] north, up, east;
  } pose_t;

  typedef struct {
    logic signed [15:0] pc, rc, yc;
    logic [12:0] thr;
    logic [15:0] dt;
    logic known;
    pose_t pose;
  } tick_row_t;

  // Predictor state and register copy.
  logic [15:0] floor_m, p_gain, r_gain, y_gain;
  logic [9:0] base_kmh, span_kmh;
  longint pitch_a, roll_a, yaw_a, east_a, up_a, north_a;
  longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  pose_t pose_q[$];
  int errors = 0;
  int cycles = 0;

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint step_angle(longint ang, logic signed [15:0] cmd,
                                        logic [15:0] gain, logic [15:0] dt);
    longint a;
    a = ang + round_shift(longint'(cmd) * longint'(gain) * longint'(dt), 31);
    if (a > 25736) a -= 51472;
    if (a < -25736) a += 51472;
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    return a;
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint z, x, y, nx;
    bit flip;
    z = ang * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_pose(input tick_row_t t, output pose_t p);
    longint thr, speed, sp, cp, sy, cy, fx, fz, vx, vy, vz, hd;
    pitch_a = step_angle(pitch_a, t.pc, p_gain, t.dt);
    roll_a = step_angle(roll_a, t.rc, r_gain, t.dt);
    yaw_a = step_angle(yaw_a, t.yc, y_gain, t.dt);
    thr = (t.thr > 13'd4096) ? 4096 : t.thr;
    speed = ((longint'(base_kmh) * 4096 + thr * span_kmh) * 40 + 4) / 9;
    rotate(pitch_a, sp, cp);
    rotate(yaw_a, sy, cy);
    fx = round_shift(cp * sy, 30);
    fz = round_shift(cp * cy, 30);
    vx = round_shift(speed * fx, 30);
    vz = round_shift(speed * fz, 30);
    vy = round_shift(speed * sp, 30);
    east_a = clip32(east_a + round_shift(vx * t.dt, 24));
    up_a = clip32(up_a + round_shift(vy * t.dt, 24));
    north_a = clip32(north_a + round_shift(vz * t.dt, 24));
    if (up_a < longint'(floor_m) * 256) begin
      up_a = longint'(floor_m) * 256;
      if (pitch_a > 819 || pitch_a < -819)
        pitch_a = round_shift(pitch_a * 9 * 4096 / 5, 13);
      else
        pitch_a = 0;
    end
    hd = round_shift(yaw_a * 58671, 16);
    if (hd < 0) hd += 46080;
    p.east = east_a;
    p.up = up_a;
    p.north = north_a;
    p.pitch = pitch_a;
    p.roll = roll_a;
    p.yaw = yaw_a;
    p.hdg = hd;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MIN_ALT: floor_m = val[15:0];
      REG_BASE_SPD: base_kmh = val[9:0];
      REG_SPAN_SPD: span_kmh = val[9:0];
      REG_P_GAIN: p_gain = val[15:0];
      REG_R_GAIN: r_gain = val[15:0];
      REG_Y_GAIN: y_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] fl, input logic [9:0] b, input logic [9:0] s,
                         input logic [15:0] pg, input logic [15:0] rg, input logic [15:0] yg);
    write_reg(REG_MIN_ALT, fl);
    write_reg(REG_BASE_SPD, b);
    write_reg(REG_SPAN_SPD, s);
    write_reg(REG_P_GAIN, pg);
    write_reg(REG_R_GAIN, rg);
    write_reg(REG_Y_GAIN, yg);
  endtask

  // The valid stays high into the next call when that one draws no idle cycles.
  task automatic send_tick(input tick_row_t t);
    pose_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {3'b000, t.dt, t.thr, t.yc, t.rc, t.pc};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_pose(t, p);
    if (t.known && p !== t.pose) begin
      $error("table row disagrees with predictor");
      errors++;
    end
    pose_q.push_back(p);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_cmd();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return $signed(16'($urandom));
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic tick_row_t rand_tick();
    tick_row_t t;
    t.pc = rand_cmd();
    t.rc = rand_cmd();
    t.yc = rand_cmd();
    t.thr = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
    t.dt = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
    t.known = 0;
    return t;
  endfunction

  // Receiver: random stalls, compare with the oldest expectation.
  initial begin
    pose_t got, want;
    int stall;
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      if (pose_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.east !== want.east) begin
          $error("east_pos exp %0d got %0d", want.east, got.east); errors++;
        end
        if (got.up !== want.up) begin
          $error("up_pos exp %0d got %0d", want.up, got.up); errors++;
        end
        if (got.north !== want.north) begin
          $error("north_pos exp %0d got %0d", want.north, got.north); errors++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_out exp %0d got %0d", want.pitch, got.pitch); errors++;
        end
        if (got.roll !== want.roll) begin
          $error("roll_out exp %0d got %0d", want.roll, got.roll); errors++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_out exp %0d got %0d", want.yaw, got.yaw); errors++;
        end
        if (got.hdg !== want.hdg) begin
          $error("heading_deg exp %0d got %0d", want.hdg, got.hdg); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_flight_kinematics_integrator: done, errors");
      $finish;
    end
  end

  initial begin
    tick_row_t table_rows[$];
    tick_row_t t;
    floor_m = 100; base_kmh = 100; span_kmh = 200;
    p_gain = 8192; r_gain = 13107; y_gain = 4915;
    pitch_a = 0; roll_a = 0; yaw_a = 0; east_a = 0; up_a = 256000; north_a = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero time step after reset: nothing moves, altitude stays at 1000 m.
    t = '{0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 256000, 0}};
    table_rows.push_back(t);
    // Full sticks, full throttle and longest step; throttle beyond full.
    table_rows.push_back('{16384, 16384, 16384, 4096, 65535, 0, '0});
    table_rows.push_back('{-16384, -16384, -16384, 8191, 65535, 0, '0});
    table_rows.push_back('{-16384, 16384, 0, 0, 65535, 0, '0});
    table_rows.push_back('{-32768, 32767, -32768, 4097, 65535, 0, '0});
    table_rows.push_back('{32767, -32768, 32767, 4096, 40000, 0, '0});
    table_rows.push_back('{16384, -16384, 16384, 2048, 1, 0, '0});
    foreach (table_rows[i]) send_tick(table_rows[i]);
    drain();

    // Maximum gains make angles run far out and wrap; the floor at its maximum holds the altitude on it.
    set_all(16'hFFFF, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    table_rows.delete();
    table_rows.push_back('{-16384, 16384, 16384, 4096, 65535, 0, '0});
    table_rows.push_back('{-16384, -16384, -16384, 4096, 65535, 0, '0});
    table_rows.push_back('{16384, 0, 16384, 4096, 30000, 0, '0});
    table_rows.push_back('{-3000, 300, 100, 4096, 65535, 0, '0});
    table_rows.push_back('{0, 0, 0, 0, 65535, 0, '0});
    foreach (table_rows[i]) send_tick(table_rows[i]);
    drain();

    set_all(16'd0, 10'd0, 10'd0, 16'd0, 16'd0, 16'd0);
    table_rows.delete();
    table_rows.push_back('{16384, 16384, 16384, 4096, 65535, 0, '0});
    table_rows.push_back('{-16384, -16384, -16384, 8191, 65535, 0, '0});
    foreach (table_rows[i]) send_tick(table_rows[i]);
    drain();

    // Random phases with fresh register settings; the last phase runs long,
    // with fast speed.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_all(16'd0, 10'd1023, 10'd1023, 16'd800, 16'hFFFF, 16'd50);
      else
        set_all(16'($urandom_range(0, 1200)), 10'($urandom), 10'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      repeat (ph == 5 ? N_RANDOM - 5 * 100 : 100) begin
        t = rand_tick();
        if (ph == 5 && $urandom_range(0, 1) == 0) begin
          t.dt = 16'hFFFF;
          t.thr = 13'd4096;
        end
        send_tick(t);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_flight_kinematics_integrator: done, clean");
    end else begin
      $display("tb_flight_kinematics_integrator: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/fki_pkg.sv
rtl/core/fki_regs.sv
rtl/core/fki_ctrl.sv
rtl/core/fki_dp.sv
rtl/core/flight_kinematics_integrator.sv
rtl/core/fki_checker.sv
tb/tb_flight_kinematics_integrator.sv
